// File: src/dbm_pkg.sv
// ----------------------------------------------------------------------------
// dbm_pkg: shared types and constants for the damped body motion core
// Register indexes, register reset values and the beat structs that
// travel between the pipeline sections.
// ----------------------------------------------------------------------------
package dbm_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_TIME_STEP         = 3'd0;
    localparam logic [2:0] REG_IMPULSE_STRENGTH  = 3'd1;
    localparam logic [2:0] REG_MIN_SPEED_SQUARED = 3'd2;
    localparam logic [2:0] REG_MAX_SPEED_SQUARED = 3'd3;
    localparam logic [2:0] REG_HALF_WIDTH        = 3'd4;
    localparam logic [2:0] REG_HALF_HEIGHT       = 3'd5;

    // register reset values
    localparam logic [15:0] TIME_STEP_RST         = 16'd1092;
    localparam logic [31:0] IMPULSE_STRENGTH_RST  = 32'd65536;
    localparam logic [62:0] MIN_SPEED_SQUARED_RST = 63'd0;
    localparam logic [62:0] MAX_SPEED_SQUARED_RST = {63{1'b1}};
    localparam logic [14:0] HALF_WIDTH_RST        = 15'd640;
    localparam logic [14:0] HALF_HEIGHT_RST       = 15'd400;

    // one input beat
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic               awake_in;
        logic        [15:0] drag;
        logic        [23:0] inverse_mass;
    } dbm_item_t;

    // body state between impulse and motion sections
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               awake;
        logic        [15:0] drag;
    } dbm_body_t;

    // one result beat
    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               awake_out;
    } dbm_result_t;

endpackage

// File: src/dbm_impulse.sv
// ----------------------------------------------------------------------------
// dbm_impulse: impulse section of the motion pipeline
// Six stages: direction times inverse mass, split strength products,
// truncation to Q16.16, candidate velocity and range check, squared speed,
// limit compare and velocity select.
// ----------------------------------------------------------------------------
module dbm_impulse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  dbm_pkg::dbm_item_t  item,
    input  logic [31:0]         impulse_strength,
    input  logic [62:0]         max_speed_squared,
    output logic                body_valid,
    input  logic                body_ready,
    output dbm_pkg::dbm_body_t  body
);

    logic [6:1] vld_reg;
    logic [6:1] en;

    dbm_pkg::dbm_body_t carry_reg [1:5];
    dbm_pkg::dbm_body_t carry_next;
    logic [5:1]         imp_reg;
    logic               imp_next;

    logic signed [15:0] dir [2];
    logic        [15:0] dmag [2];
    logic        [39:0] prod1 [2];

    logic [38:0] mag1_reg [2];
    logic [38:0] mag1_next [2];
    logic        neg1_reg [2];
    logic        neg1_next [2];

    logic [54:0] a2_reg [2];
    logic [54:0] a2_next [2];
    logic [54:0] b2_reg [2];
    logic [54:0] b2_next [2];
    logic        neg2_reg [2];

    logic [55:0] low3 [2];
    logic [41:0] r3_reg [2];
    logic [41:0] r3_next [2];
    logic        neg3_reg [2];

    logic signed [31:0] v3 [2];
    logic signed [43:0] nx4 [2];
    logic signed [31:0] nx4_reg [2];
    logic signed [31:0] nx4_next [2];
    logic               ok4_reg [2];
    logic               ok4_next [2];

    logic        [31:0] m5 [2];
    logic        [63:0] sq5_reg [2];
    logic        [63:0] sq5_next [2];
    logic signed [31:0] nx5_reg [2];
    logic               ok5_reg [2];

    logic [64:0]        sum6;
    logic               take6;
    dbm_pkg::dbm_body_t body_reg;
    dbm_pkg::dbm_body_t body_next;

    // per-stage load enable: a stage loads when empty or when its successor moves
    always_comb
    begin
        en[6] = !vld_reg[6] || body_ready;
        for (int k = 5; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign item_ready = en[1];
    assign body_valid = vld_reg[6];
    assign body       = body_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= item_valid;
            end
            for (int k = 2; k <= 6; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: |dir| * inverse mass
    always_comb
    begin
        dir[0] = item.dir_x;
        dir[1] = item.dir_y;
        for (int a = 0; a < 2; a++)
        begin
            dmag[a]      = dir[a][15] ? (~dir[a] + 16'd1) : dir[a];
            prod1[a]     = dmag[a] * item.inverse_mass;
            mag1_next[a] = prod1[a][38:0];
            neg1_next[a] = dir[a][15];
        end
        imp_next   = ((item.dir_x != 16'sd0) || (item.dir_y != 16'sd0))
                     && (impulse_strength != 32'd0);
        carry_next.pos_x = item.pos_x;
        carry_next.pos_y = item.pos_y;
        carry_next.vel_x = item.vel_x;
        carry_next.vel_y = item.vel_y;
        carry_next.awake = item.awake_in;
        carry_next.drag  = item.drag;
    end

    // stage 2: split strength products
    // stage 3: recombine with 30 fraction bits dropped
    // stage 4: candidate velocity and Q16.16 range check
    // stage 5: squared components
    always_comb
    begin
        v3[0] = carry_reg[3].vel_x;
        v3[1] = carry_reg[3].vel_y;
        for (int a = 0; a < 2; a++)
        begin
            a2_next[a] = mag1_reg[a] * impulse_strength[31:16];
            b2_next[a] = mag1_reg[a] * impulse_strength[15:0];

            low3[a]    = {26'd0, a2_reg[a][13:0], 16'd0} + {1'b0, b2_reg[a]};
            r3_next[a] = a2_reg[a][54:14] + {16'd0, low3[a][55:30]};

            nx4[a]      = neg3_reg[a] ? ({{12{v3[a][31]}}, v3[a]} - {2'b00, r3_reg[a]})
                                      : ({{12{v3[a][31]}}, v3[a]} + {2'b00, r3_reg[a]});
            nx4_next[a] = nx4[a][31:0];
            ok4_next[a] = (nx4[a][43:31] == 13'd0) || (nx4[a][43:31] == {13{1'b1}});

            m5[a]       = nx4_reg[a][31] ? (~nx4_reg[a] + 32'd1) : nx4_reg[a];
            sq5_next[a] = m5[a] * m5[a];
        end
    end

    // stage 6: limit compare, keep old velocity on rejection
    always_comb
    begin
        sum6  = {1'b0, sq5_reg[0]} + {1'b0, sq5_reg[1]};
        take6 = imp_reg[5] && ok5_reg[0] && ok5_reg[1]
                && (sum6 <= {2'b00, max_speed_squared});
        body_next       = carry_reg[5];
        body_next.awake = carry_reg[5].awake || imp_reg[5];
        if (take6)
        begin
            body_next.vel_x = nx5_reg[0];
            body_next.vel_y = nx5_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            carry_reg[1] <= carry_next;
            imp_reg[1]   <= imp_next;
            mag1_reg     <= mag1_next;
            neg1_reg     <= neg1_next;
        end
        if (en[2])
        begin
            carry_reg[2] <= carry_reg[1];
            imp_reg[2]   <= imp_reg[1];
            a2_reg       <= a2_next;
            b2_reg       <= b2_next;
            neg2_reg     <= neg1_reg;
        end
        if (en[3])
        begin
            carry_reg[3] <= carry_reg[2];
            imp_reg[3]   <= imp_reg[2];
            r3_reg       <= r3_next;
            neg3_reg     <= neg2_reg;
        end
        if (en[4])
        begin
            carry_reg[4] <= carry_reg[3];
            imp_reg[4]   <= imp_reg[3];
            nx4_reg      <= nx4_next;
            ok4_reg      <= ok4_next;
        end
        if (en[5])
        begin
            carry_reg[5] <= carry_reg[4];
            imp_reg[5]   <= imp_reg[4];
            sq5_reg      <= sq5_next;
            nx5_reg      <= nx4_reg;
            ok5_reg      <= ok4_reg;
        end
        if (en[6])
        begin
            body_reg <= body_next;
        end
    end

endmodule

// File: src/dbm_motion.sv
// ----------------------------------------------------------------------------
// dbm_motion: drag, stop test and integration section of the pipeline
// Five stages: drag product, damped velocity and velocity sum, squared
// speed and displacement product, stop compare and saturated position,
// wrap and result register.
// ----------------------------------------------------------------------------
module dbm_motion (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                body_valid,
    output logic                body_ready,
    input  dbm_pkg::dbm_body_t  body,
    input  logic [15:0]         time_step,
    input  logic [62:0]         min_speed_squared,
    input  logic [14:0]         half_width,
    input  logic [14:0]         half_height,
    output logic                res_valid,
    input  logic                res_ready,
    output dbm_pkg::dbm_result_t res
);

    logic [5:1] vld_reg;
    logic [5:1] en;

    logic signed [31:0] vin [2];
    logic signed [31:0] pin [2];
    logic        [31:0] vmag [2];
    logic        [47:0] dp7_next [2];

    logic        [47:0] dp7_reg [2];
    logic               neg7_reg [2];
    logic signed [31:0] v7_reg [2];
    logic signed [31:0] p7_reg [2];
    logic               awake7_reg;

    logic signed [32:0] v7x [2];
    logic signed [32:0] wx8_next [2];
    logic signed [33:0] s8_next [2];
    logic signed [32:0] wx8_reg [2];
    logic signed [33:0] s8_reg [2];
    logic signed [31:0] v8_reg [2];
    logic signed [31:0] p8_reg [2];
    logic               awake8_reg;

    logic        [32:0] wmag [2];
    logic        [33:0] smag [2];
    logic        [32:0] smag33 [2];
    logic        [63:0] sq9_next [2];
    logic        [48:0] dp9_next [2];
    logic        [63:0] sq9_reg [2];
    logic        [48:0] dp9_reg [2];
    logic               neg9_reg [2];
    logic signed [31:0] wx9_reg [2];
    logic signed [31:0] v9_reg [2];
    logic signed [31:0] p9_reg [2];
    logic               awake9_reg;

    logic        [64:0] sum10;
    logic               moving10_next;
    logic        [33:0] disp10 [2];
    logic signed [33:0] q10 [2];
    logic signed [31:0] q10_next [2];
    logic signed [31:0] q10_reg [2];
    logic signed [31:0] wx10_reg [2];
    logic signed [31:0] v10_reg [2];
    logic signed [31:0] p10_reg [2];
    logic               moving10_reg;
    logic               awake10_reg;

    logic [14:0]        half [2];
    logic signed [31:0] bnd [2];
    logic signed [31:0] nbnd [2];
    logic signed [31:0] wp [2];
    dbm_pkg::dbm_result_t res_reg;
    dbm_pkg::dbm_result_t res_next;

    always_comb
    begin
        en[5] = !vld_reg[5] || res_ready;
        for (int k = 4; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign body_ready = en[1];
    assign res_valid  = vld_reg[5];
    assign res        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= body_valid;
            end
            for (int k = 2; k <= 5; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        vin[0] = body.vel_x;
        vin[1] = body.vel_y;
        pin[0] = body.pos_x;
        pin[1] = body.pos_y;
        half[0] = half_width;
        half[1] = half_height;
        for (int a = 0; a < 2; a++)
        begin
            // stage 7: |v| * drag
            vmag[a]     = vin[a][31] ? (~vin[a] + 32'd1) : vin[a];
            dp7_next[a] = vmag[a] * body.drag;

            // stage 8: damped velocity and pre plus post velocity sum
            v7x[a]      = {v7_reg[a][31], v7_reg[a]};
            wx8_next[a] = neg7_reg[a] ? (v7x[a] + {1'b0, dp7_reg[a][47:16]})
                                      : (v7x[a] - {1'b0, dp7_reg[a][47:16]});
            s8_next[a]  = {v7x[a][32], v7x[a]} + {wx8_next[a][32], wx8_next[a]};

            // stage 9: squared damped speed and |sum| * dt
            wmag[a]     = wx8_reg[a][32] ? (~wx8_reg[a] + 33'd1) : wx8_reg[a];
            sq9_next[a] = wmag[a][31:0] * wmag[a][31:0];
            smag[a]     = s8_reg[a][33] ? (~s8_reg[a] + 34'd1) : s8_reg[a];
            smag33[a]   = smag[a][32:0];
            dp9_next[a] = smag33[a] * time_step;

            // stage 10: position advance with saturation
            disp10[a]   = {2'b00, dp9_reg[a][48:17]};
            q10[a]      = neg9_reg[a] ? ({{2{p9_reg[a][31]}}, p9_reg[a]} - disp10[a])
                                      : ({{2{p9_reg[a][31]}}, p9_reg[a]} + disp10[a]);
            if ((q10[a][33:31] == 3'b000) || (q10[a][33:31] == 3'b111))
            begin
                q10_next[a] = q10[a][31:0];
            end
            else if (q10[a][33])
            begin
                q10_next[a] = {1'b1, 31'd0};
            end
            else
            begin
                q10_next[a] = {1'b0, {31{1'b1}}};
            end

            // stage 11: wrap to the opposite edge
            bnd[a]  = {1'b0, half[a], 16'd0};
            nbnd[a] = -bnd[a];
            if (q10_reg[a] < nbnd[a])
            begin
                wp[a] = bnd[a];
            end
            else if (q10_reg[a] > bnd[a])
            begin
                wp[a] = nbnd[a];
            end
            else
            begin
                wp[a] = q10_reg[a];
            end
        end
        sum10         = {1'b0, sq9_reg[0]} + {1'b0, sq9_reg[1]};
        moving10_next = awake9_reg && (sum10 > {2'b00, min_speed_squared});
    end

    // result select: sleeping body passes through, stopped body zeroes velocity
    always_comb
    begin
        res_next.awake_out = moving10_reg;
        if (moving10_reg)
        begin
            res_next.new_pos_x = wp[0];
            res_next.new_pos_y = wp[1];
            res_next.new_vel_x = wx10_reg[0];
            res_next.new_vel_y = wx10_reg[1];
        end
        else if (awake10_reg)
        begin
            res_next.new_pos_x = p10_reg[0];
            res_next.new_pos_y = p10_reg[1];
            res_next.new_vel_x = '0;
            res_next.new_vel_y = '0;
        end
        else
        begin
            res_next.new_pos_x = p10_reg[0];
            res_next.new_pos_y = p10_reg[1];
            res_next.new_vel_x = v10_reg[0];
            res_next.new_vel_y = v10_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 2; a++)
        begin
            if (en[1])
            begin
                dp7_reg[a]  <= dp7_next[a];
                neg7_reg[a] <= vin[a][31];
                v7_reg[a]   <= vin[a];
                p7_reg[a]   <= pin[a];
            end
            if (en[2])
            begin
                wx8_reg[a] <= wx8_next[a];
                s8_reg[a]  <= s8_next[a];
                v8_reg[a]  <= v7_reg[a];
                p8_reg[a]  <= p7_reg[a];
            end
            if (en[3])
            begin
                sq9_reg[a]  <= sq9_next[a];
                dp9_reg[a]  <= dp9_next[a];
                neg9_reg[a] <= s8_reg[a][33];
                wx9_reg[a]  <= wx8_reg[a][31:0];
                v9_reg[a]   <= v8_reg[a];
                p9_reg[a]   <= p8_reg[a];
            end
            if (en[4])
            begin
                q10_reg[a]  <= q10_next[a];
                wx10_reg[a] <= wx9_reg[a];
                v10_reg[a]  <= v9_reg[a];
                p10_reg[a]  <= p9_reg[a];
            end
        end
        if (en[1])
        begin
            awake7_reg <= body.awake;
        end
        if (en[2])
        begin
            awake8_reg <= awake7_reg;
        end
        if (en[3])
        begin
            awake9_reg <= awake8_reg;
        end
        if (en[4])
        begin
            awake10_reg  <= awake9_reg;
            moving10_reg <= moving10_next;
        end
        if (en[5])
        begin
            res_reg <= res_next;
        end
    end

endmodule

// File: src/damped_body_motion_update_core.sv
// ----------------------------------------------------------------------------
// damped_body_motion_update_core: fixed point body motion update
// Applies a direction impulse with a speed limit, drag, a stop test,
// trapezoidal position integration and edge wrap to one body per beat.
// ----------------------------------------------------------------------------
// usage
//   input channel  in_valid/in_ready: one body per beat (position, velocity,
//                  direction, awake flag, drag, inverse mass)
//   output channel out_valid/out_ready: one updated body per input beat,
//                  in input order
//   config channel cfg_valid/cfg_ready: cfg_index selects the register,
//                  cfg_data carries the value; always ready, write only
//                  while no beat is in flight
//   path: a result passes the six impulse stages, then the five motion
//         stages, with the output register last
//   throughput: one beat per cycle while out_ready is high, set by the
//               eleven-stage pipeline in which every stage takes a new beat
//   stall: each stage loads when empty or when the stage after it moves,
//          so bubbles are squeezed out, in_ready is low only while all eleven
//          stages are full and out_ready low; nothing is dropped or repeated
//   reset: all stages empty, registers back to their reset values
// ----------------------------------------------------------------------------
module damped_body_motion_update_core (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic               awake_in,
    input  logic        [15:0] drag,
    input  logic        [23:0] inverse_mass,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic               awake_out,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [2:0]  cfg_index,
    input  logic        [62:0] cfg_data
);

    // configuration registers
    logic [15:0] time_step_reg;
    logic [31:0] impulse_strength_reg;
    logic [62:0] min_speed_squared_reg;
    logic [62:0] max_speed_squared_reg;
    logic [14:0] half_width_reg;
    logic [14:0] half_height_reg;

    dbm_pkg::dbm_item_t   item;
    dbm_pkg::dbm_body_t   body;
    dbm_pkg::dbm_result_t res;
    logic                 body_valid;
    logic                 body_ready;

    // config writes take effect at once; indexes past the list are ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg         <= dbm_pkg::TIME_STEP_RST;
            impulse_strength_reg  <= dbm_pkg::IMPULSE_STRENGTH_RST;
            min_speed_squared_reg <= dbm_pkg::MIN_SPEED_SQUARED_RST;
            max_speed_squared_reg <= dbm_pkg::MAX_SPEED_SQUARED_RST;
            half_width_reg        <= dbm_pkg::HALF_WIDTH_RST;
            half_height_reg       <= dbm_pkg::HALF_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dbm_pkg::REG_TIME_STEP:         time_step_reg         <= cfg_data[15:0];
                dbm_pkg::REG_IMPULSE_STRENGTH:  impulse_strength_reg  <= cfg_data[31:0];
                dbm_pkg::REG_MIN_SPEED_SQUARED: min_speed_squared_reg <= cfg_data;
                dbm_pkg::REG_MAX_SPEED_SQUARED: max_speed_squared_reg <= cfg_data;
                dbm_pkg::REG_HALF_WIDTH:        half_width_reg        <= cfg_data[14:0];
                dbm_pkg::REG_HALF_HEIGHT:       half_height_reg       <= cfg_data[14:0];
                default:
                begin
                end
            endcase
        end
    end

    // pack the input beat
    always_comb
    begin
        item.pos_x        = pos_x;
        item.pos_y        = pos_y;
        item.vel_x        = vel_x;
        item.vel_y        = vel_y;
        item.dir_x        = dir_x;
        item.dir_y        = dir_y;
        item.awake_in     = awake_in;
        item.drag         = drag;
        item.inverse_mass = inverse_mass;
    end

    // impulse, speed limit and wake-up
    dbm_impulse u_impulse (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (in_valid),
        .item_ready        (in_ready),
        .item              (item),
        .impulse_strength  (impulse_strength_reg),
        .max_speed_squared (max_speed_squared_reg),
        .body_valid        (body_valid),
        .body_ready        (body_ready),
        .body              (body)
    );

    // drag, stop test, integration and wrap
    dbm_motion u_motion (
        .clk               (clk),
        .rst_n             (rst_n),
        .body_valid        (body_valid),
        .body_ready        (body_ready),
        .body              (body),
        .time_step         (time_step_reg),
        .min_speed_squared (min_speed_squared_reg),
        .half_width        (half_width_reg),
        .half_height       (half_height_reg),
        .res_valid         (out_valid),
        .res_ready         (out_ready),
        .res               (res)
    );

    assign new_pos_x = res.new_pos_x;
    assign new_pos_y = res.new_pos_y;
    assign new_vel_x = res.new_vel_x;
    assign new_vel_y = res.new_vel_y;
    assign awake_out = res.awake_out;

endmodule

// File: bench/tb_damped_body_motion_update_core.sv
// ----------------------------------------------------------------------------
// tb_damped_body_motion_update_core: self-checking bench for the body update
// Feeds bodies through the valid/ready input channel, predicts each updated
// body in fixed point, and compares every output beat in order. A directed
// table runs twice, then phases of random bodies under changing registers,
// with random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_damped_body_motion_update_core;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int PIPE_DEPTH   = 11;
    localparam int PHASES       = 8;
    localparam int PHASE_BODIES = 225;
    localparam int SHOWN_ERRORS = 40;
    localparam int TIMEOUT      = 10_000_000;
    localparam int DRILL_ROWS   = 14;

    localparam logic signed [63:0] Q16_HI = 64'sd2147483647;
    localparam logic signed [63:0] Q16_LO = -64'sd2147483648;

    // ------------------------------------------------------------------
    // dut signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic signed [31:0] pos_x        = '0;
    logic signed [31:0] pos_y        = '0;
    logic signed [31:0] vel_x        = '0;
    logic signed [31:0] vel_y        = '0;
    logic signed [15:0] dir_x        = '0;
    logic signed [15:0] dir_y        = '0;
    logic               awake_in     = 1'b0;
    logic        [15:0] drag         = '0;
    logic        [23:0] inverse_mass = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic               awake_out;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic        [2:0]  cfg_index    = '0;
    logic        [62:0] cfg_data     = '0;

    damped_body_motion_update_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .vel_x        (vel_x),
        .vel_y        (vel_y),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .awake_in     (awake_in),
        .drag         (drag),
        .inverse_mass (inverse_mass),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .new_pos_x    (new_pos_x),
        .new_pos_y    (new_pos_y),
        .new_vel_x    (new_vel_x),
        .new_vel_y    (new_vel_y),
        .awake_out    (awake_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // bench copy of the registers, updated on each accepted config beat
    // ------------------------------------------------------------------
    logic [15:0] time_step_q        = dbm_pkg::TIME_STEP_RST;
    logic [31:0] impulse_strength_q = dbm_pkg::IMPULSE_STRENGTH_RST;
    logic [62:0] min_speed_sq_q     = dbm_pkg::MIN_SPEED_SQUARED_RST;
    logic [62:0] max_speed_sq_q     = dbm_pkg::MAX_SPEED_SQUARED_RST;
    logic [14:0] half_width_q       = dbm_pkg::HALF_WIDTH_RST;
    logic [14:0] half_height_q      = dbm_pkg::HALF_HEIGHT_RST;

    // updated bodies still owed by the dut, oldest first
    dbm_pkg::dbm_result_t motion_q[$];
    int                   error_count = 0;
    // no gaps and no stalls while set
    logic                 steady      = 1'b0;
    int                   hold_left   = 0;

    // ------------------------------------------------------------------
    // directed table: typed-in results only where they are obvious under
    // the reset register values, the rest go through the predictor
    // ------------------------------------------------------------------
    typedef struct packed {
        dbm_pkg::dbm_item_t   body;
        logic                 typed;
        dbm_pkg::dbm_result_t want;
    } drill_row_t;

    drill_row_t drill [DRILL_ROWS] = '{
        // sleeping body with extreme fields passes through untouched
        '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
            16'h0000, 16'h0000, 1'b0, 16'hFFFF, 24'hFF_FFFF},
          1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0}},
        // awake at rest stops at once
        '{'{32'h0012_3456, 32'hFFF0_0000, 32'h0, 32'h0,
            16'h0000, 16'h0000, 1'b1, 16'h1000, 24'h01_0000},
          1'b1, '{32'h0012_3456, 32'hFFF0_0000, 32'h0, 32'h0, 1'b0}},
        // top of x range saturates then wraps to the left edge
        '{'{32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h0,
            16'h0000, 16'h0000, 1'b1, 16'h0000, 24'h00_0000},
          1'b1, '{32'hFD80_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 1'b1}},
        // bottom of x range saturates then wraps to the right edge
        '{'{32'h8000_0000, 32'h0, 32'h8000_0000, 32'h0,
            16'h0000, 16'h0000, 1'b1, 16'h0000, 24'h00_0000},
          1'b1, '{32'h0280_0000, 32'h0, 32'h8000_0000, 32'h0, 1'b1}},
        // same two on the y axis
        '{'{32'h0, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF,
            16'h0000, 16'h0000, 1'b1, 16'h0000, 24'h00_0000},
          1'b1, '{32'h0, 32'hFE70_0000, 32'h0, 32'h7FFF_FFFF, 1'b1}},
        '{'{32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000,
            16'h0000, 16'h0000, 1'b1, 16'h0000, 24'h00_0000},
          1'b1, '{32'h0, 32'h0190_0000, 32'h0, 32'h8000_0000, 1'b1}},
        // sitting exactly on the bounds does not wrap
        '{'{32'h0280_0000, 32'hFE70_0000, 32'h1, 32'h0,
            16'h0000, 16'h0000, 1'b1, 16'h0000, 24'h00_0000},
          1'b1, '{32'h0280_0000, 32'hFE70_0000, 32'h1, 32'h0, 1'b1}},
        // one lsb past the bounds wraps
        '{'{32'h0280_0001, 32'hFE6F_FFFF, 32'h1, 32'h0,
            16'h0000, 16'h0000, 1'b1, 16'h0000, 24'h00_0000},
          1'b1, '{32'hFD80_0000, 32'h0190_0000, 32'h1, 32'h0, 1'b1}},
        // direction with zero inverse mass wakes, then stops right away
        '{'{32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0,
            16'h4000, 16'hC000, 1'b0, 16'h0000, 24'h00_0000},
          1'b1, '{32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 1'b0}},
        // unit impulse on a sleeping body
        '{'{32'h0, 32'h0, 32'h0, 32'h0,
            16'h4000, 16'h0000, 1'b0, 16'h0000, 24'h01_0000}, 1'b0, '0},
        // impulse pushes x velocity past the top of the range
        '{'{32'h1234_5678, 32'hEDCB_A988, 32'h7FFF_0000, 32'h0,
            16'h7FFF, 16'h0000, 1'b1, 16'h0100, 24'hFF_FFFF}, 1'b0, '0},
        // impulse pushes y velocity past the bottom of the range
        '{'{32'hF000_0000, 32'h0100_0000, 32'h0, 32'h8001_0000,
            16'h0000, 16'h8000, 1'b0, 16'h0000, 24'hFF_FFFF}, 1'b0, '0},
        // full drag
        '{'{32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000,
            16'h0000, 16'h0000, 1'b1, 16'hFFFF, 24'h00_0000}, 1'b0, '0},
        // extreme direction on both axes with half drag
        '{'{32'h0100_0000, 32'hFF00_0000, 32'hFFFF_0000, 32'h0003_0000,
            16'h8000, 16'h7FFF, 1'b1, 16'h8000, 24'h01_0000}, 1'b0, '0}
    };

    // ------------------------------------------------------------------
    // fixed point predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] signed_from(input logic [63:0] m,
                                                       input logic neg);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // truncate toward zero of v * f / 2^sh
    function automatic logic signed [63:0] scaled(input logic signed [63:0] v,
                                                  input logic [63:0] f,
                                                  input int sh);
        return signed_from((magnitude(v) * f) >> sh, v[63]);
    endfunction

    // direction * inverse mass * strength carries 46 fraction bits
    function automatic logic signed [63:0] impulse_step(input logic signed [15:0] d,
                                                        input logic [23:0] inv_mass);
        logic [79:0] m;
        m = 80'(magnitude(d)) * 80'(inv_mass) * 80'(impulse_strength_q);
        return signed_from(64'(m >> 30), d[15]);
    endfunction

    function automatic logic [63:0] speed_squared(input logic signed [63:0] vx,
                                                  input logic signed [63:0] vy);
        logic [63:0] ax;
        logic [63:0] ay;
        ax = magnitude(vx);
        ay = magnitude(vy);
        return ax * ax + ay * ay;
    endfunction

    function automatic logic signed [63:0] saturate(input logic signed [63:0] v);
        return (v > Q16_HI) ? Q16_HI : ((v < Q16_LO) ? Q16_LO : v);
    endfunction

    function automatic logic signed [63:0] wrap_edge(input logic signed [63:0] p,
                                                     input logic [14:0] half);
        logic signed [63:0] bound;
        bound = $signed({33'b0, half, 16'b0});
        if (p < -bound)
            return bound;
        if (p > bound)
            return -bound;
        return p;
    endfunction

    function automatic dbm_pkg::dbm_result_t predict_motion(input dbm_pkg::dbm_item_t b);
        logic signed [63:0]   px;
        logic signed [63:0]   py;
        logic signed [63:0]   vx;
        logic signed [63:0]   vy;
        logic signed [63:0]   nx;
        logic signed [63:0]   ny;
        logic signed [63:0]   wx;
        logic signed [63:0]   wy;
        logic                 awake;
        dbm_pkg::dbm_result_t r;
        px    = $signed(b.pos_x);
        py    = $signed(b.pos_y);
        vx    = $signed(b.vel_x);
        vy    = $signed(b.vel_y);
        awake = b.awake_in;
        // impulse wakes the body even when the new velocity is refused
        if ((b.dir_x != 0 || b.dir_y != 0) && impulse_strength_q != 0)
        begin
            nx    = vx + impulse_step(b.dir_x, b.inverse_mass);
            ny    = vy + impulse_step(b.dir_y, b.inverse_mass);
            awake = 1'b1;
            if (nx >= Q16_LO && nx <= Q16_HI && ny >= Q16_LO && ny <= Q16_HI &&
                speed_squared(nx, ny) <= {1'b0, max_speed_sq_q})
            begin
                vx = nx;
                vy = ny;
            end
        end
        if (awake)
        begin
            wx = vx - scaled(vx, 64'(b.drag), 16);
            wy = vy - scaled(vy, 64'(b.drag), 16);
            if (speed_squared(wx, wy) > {1'b0, min_speed_sq_q})
            begin
                // trapezoid of pre-drag and post-drag velocity
                px = wrap_edge(saturate(px + scaled(vx + wx, 64'(time_step_q), 17)),
                               half_width_q);
                py = wrap_edge(saturate(py + scaled(vy + wy, 64'(time_step_q), 17)),
                               half_height_q);
                vx = wx;
                vy = wy;
            end
            else
            begin
                vx    = '0;
                vy    = '0;
                awake = 1'b0;
            end
        end
        r.new_pos_x = px[31:0];
        r.new_pos_y = py[31:0];
        r.new_vel_x = vx[31:0];
        r.new_vel_y = vy[31:0];
        r.awake_out = awake;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random bodies
    // ------------------------------------------------------------------
    // value in [-span, span]
    function automatic logic [31:0] spread(input logic [31:0] span);
        logic [31:0] u;
        u = $urandom_range(0, span);
        return ($urandom_range(0, 1) == 1) ? -u : u;
    endfunction

    function automatic logic [31:0] pick_velocity();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return spread(32'h0000_1000);
        if (pick < 8)
            return spread(32'h0040_0000);
        return $urandom;
    endfunction

    function automatic dbm_pkg::dbm_item_t random_body();
        dbm_pkg::dbm_item_t b;
        int                 pick;
        // a slice of pure noise so every bit of every field toggles
        if ($urandom_range(0, 99) < 15)
        begin
            b.pos_x        = $urandom;
            b.pos_y        = $urandom;
            b.vel_x        = $urandom;
            b.vel_y        = $urandom;
            b.dir_x        = 16'($urandom);
            b.dir_y        = 16'($urandom);
            b.awake_in     = 1'($urandom);
            b.drag         = 16'($urandom);
            b.inverse_mass = 24'($urandom);
            return b;
        end
        // a plausible body somewhere around the play field
        b.pos_x    = spread({1'b0, half_width_q, 16'h0} + 32'h0004_0000);
        b.pos_y    = spread({1'b0, half_height_q, 16'h0} + 32'h0004_0000);
        b.vel_x    = pick_velocity();
        b.vel_y    = pick_velocity();
        b.awake_in = ($urandom_range(0, 9) < 8);
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            b.dir_x = '0;
            b.dir_y = '0;
        end
        else if (pick < 7)
        begin
            b.dir_x = 16'(spread(32'd16384));
            b.dir_y = 16'(spread(32'd16384));
        end
        else
        begin
            b.dir_x = 16'($urandom);
            b.dir_y = 16'($urandom);
        end
        pick = $urandom_range(0, 9);
        if (pick < 5)
            b.drag = 16'($urandom_range(0, 4096));
        else if (pick < 8)
            b.drag = 16'($urandom);
        else if (pick < 9)
            b.drag = '0;
        else
            b.drag = 16'hFFFF;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            b.inverse_mass = 24'h01_0000;
        else if (pick < 8)
            b.inverse_mass = 24'($urandom_range(0, 32'h0010_0000));
        else
            b.inverse_mass = 24'($urandom);
        return b;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------
    // offers one body and books its expected update once the beat is taken;
    // valid stays high on return so the next body can follow without a bubble
    task automatic feed_body(input dbm_pkg::dbm_item_t b, input logic typed,
                             input dbm_pkg::dbm_result_t want);
        int gap;
        gap = idle_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        pos_x        <= b.pos_x;
        pos_y        <= b.pos_y;
        vel_x        <= b.vel_x;
        vel_y        <= b.vel_y;
        dir_x        <= b.dir_x;
        dir_y        <= b.dir_y;
        awake_in     <= b.awake_in;
        drag         <= b.drag;
        inverse_mass <= b.inverse_mass;
        do @(posedge clk); while (!in_ready);
        motion_q.push_back(typed ? want : predict_motion(b));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [62:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            dbm_pkg::REG_TIME_STEP:         time_step_q        = value[15:0];
            dbm_pkg::REG_IMPULSE_STRENGTH:  impulse_strength_q = value[31:0];
            dbm_pkg::REG_MIN_SPEED_SQUARED: min_speed_sq_q     = value;
            dbm_pkg::REG_MAX_SPEED_SQUARED: max_speed_sq_q     = value;
            dbm_pkg::REG_HALF_WIDTH:        half_width_q       = value[14:0];
            dbm_pkg::REG_HALF_HEIGHT:       half_height_q      = value[14:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] ts, input logic [31:0] strength,
                             input logic [62:0] min_sq, input logic [62:0] max_sq,
                             input logic [14:0] half_w, input logic [14:0] half_h);
        write_reg(dbm_pkg::REG_TIME_STEP, 63'(ts));
        write_reg(dbm_pkg::REG_IMPULSE_STRENGTH, 63'(strength));
        write_reg(dbm_pkg::REG_MIN_SPEED_SQUARED, min_sq);
        write_reg(dbm_pkg::REG_MAX_SPEED_SQUARED, max_sq);
        write_reg(dbm_pkg::REG_HALF_WIDTH, 63'(half_w));
        write_reg(dbm_pkg::REG_HALF_HEIGHT, 63'(half_h));
        cfg_valid <= 1'b0;
    endtask

    // every body gives one update, so an empty queue means an idle pipeline
    task automatic drain();
        while (motion_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (error_count < SHOWN_ERRORS)
            $display("ERROR %0t %s got %h want %h", $realtime, what, got, exp_val);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls, long ones now and then
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 99) < 25)
        begin
            hold_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // each accepted output beat is held against the oldest expectation
    always @(posedge clk)
    begin : result_check
        dbm_pkg::dbm_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (motion_q.size() == 0)
            begin
                report_mismatch("result beat with nothing pending", new_pos_x, '0);
            end
            else
            begin
                want = motion_q.pop_front();
                if (new_pos_x !== want.new_pos_x)
                    report_mismatch("new_pos_x", new_pos_x, want.new_pos_x);
                if (new_pos_y !== want.new_pos_y)
                    report_mismatch("new_pos_y", new_pos_y, want.new_pos_y);
                if (new_vel_x !== want.new_vel_x)
                    report_mismatch("new_vel_x", new_vel_x, want.new_vel_x);
                if (new_vel_y !== want.new_vel_y)
                    report_mismatch("new_vel_y", new_vel_y, want.new_vel_y);
                if (awake_out !== want.awake_out)
                    report_mismatch("awake_out", 32'(awake_out), 32'(want.awake_out));
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [31:0] slow;
        logic [31:0] fast;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under reset values, typed results where given
        for (int i = 0; i < DRILL_ROWS; i++)
            feed_body(drill[i].body, drill[i].typed, drill[i].want);
        in_valid <= 1'b0;
        drain();

        // same table again with a tight setup: long tick, huge impulses,
        // low speed limit, a stop threshold, zero half width, full half height
        write_all(16'hFFFF, 32'hFFFF_FFFF, 63'h0000_0001_0000_0000,
                  63'h0000_0100_0000_0000, 15'd0, 15'd32767);
        for (int i = 0; i < DRILL_ROWS; i++)
            feed_body(drill[i].body, 1'b0, '0);
        in_valid <= 1'b0;
        drain();

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            steady <= (p % 3 == 2);
            case (p)
                0: write_all(dbm_pkg::TIME_STEP_RST, dbm_pkg::IMPULSE_STRENGTH_RST,
                             dbm_pkg::MIN_SPEED_SQUARED_RST,
                             dbm_pkg::MAX_SPEED_SQUARED_RST,
                             dbm_pkg::HALF_WIDTH_RST, dbm_pkg::HALF_HEIGHT_RST);
                1: write_all('1, '1, '1, '1, '1, '1);
                2: write_all('0, '0, '0, '0, '0, '0);
                default:
                begin
                    slow = $urandom_range(0, 32'h0000_2000);
                    fast = $urandom_range(32'h0001_0000, 32'h0400_0000);
                    write_all(16'($urandom_range(256, 8192)),
                              $urandom_range(32'h0000_4000, 32'h0010_0000),
                              63'(64'(slow) * 64'(slow)),
                              63'(64'(fast) * 64'(fast)),
                              15'($urandom_range(1, 2000)),
                              15'($urandom_range(1, 2000)));
                end
            endcase
            for (int n = 0; n < PHASE_BODIES; n++)
                feed_body(random_body(), 1'b0, '0);
            in_valid <= 1'b0;
            drain();
        end

        // let any stray beat surface before the verdict
        steady <= 1'b0;
        repeat (3 * PIPE_DEPTH) @(posedge clk);
        if (error_count == 0)
            $display("damped_body_motion_update_core: match");
        else
            $display("damped_body_motion_update_core: mismatch");
        $finish;
    end

    // hard stop if a handshake never completes
    initial
    begin
        #TIMEOUT;
        $display("damped_body_motion_update_core: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
src/dbm_pkg.sv
src/dbm_impulse.sv
src/dbm_motion.sv
src/damped_body_motion_update_core.sv
bench/tb_damped_body_motion_update_core.sv
